// ----- rtl/crsf_pkg.sv -----
// Shared constants, types and the CRC-8 (poly 0xD5) byte update for the frame deframer.
// No dependencies; imported by crsf_frame_deframer_crc_check.
package crsf_pkg;

    localparam int MAX_FRAME = 64;
    localparam int LEN_W     = $clog2(MAX_FRAME - 1);
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int HDR_N     = 5;

    localparam logic [7:0] SYNC_MAIN    = 8'hC8;
    localparam logic [7:0] OWN_ADDR_RST = 8'hEE;
    localparam logic [7:0] CRC_POLY     = 8'hD5;
    localparam logic [7:0] TYPE_PING    = 8'h28;
    localparam logic [7:0] TYPE_PREAD   = 8'h2C;
    localparam logic [7:0] TYPE_PWRITE  = 8'h2D;
    localparam logic [7:0] ADDR_BCAST   = 8'h00;
    localparam logic [7:0] LEN_MIN      = 8'd2;
    localparam logic [7:0] LEN_MAX      = 8'(MAX_FRAME - 2);

    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        V_BAD_CRC    = 3'd0,
        V_TOO_SHORT  = 3'd1,
        V_PING_US    = 3'd2,
        V_PING_OTHER = 3'd3,
        V_PREAD      = 3'd4,
        V_PWRITE     = 3'd5,
        V_IGNORED    = 3'd6
    } verdict_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/crsf_frame_deframer_crc_check.sv -----
// Serial frame deframer with CRC-8 check: sync hunt, length check, header capture, verdict.
// Depends on crsf_pkg (constants, phase and verdict types, CRC byte update).
//
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) carries one received serial
//   byte per transfer. Output channel (out_valid / out_stall / fields) carries
//   one result per completed frame; bytes that do not end a frame give none.
//   The config channel (cfg_valid / cfg_ready / own_address) writes the module
//   address; cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   A transferred byte sits in the input register and is processed from
//   there; its result, if any, goes straight into the result register.
//   One byte per cycle is sustained unless a frame-ending byte is held
//   (see Stall): the per-byte CRC update and parser step form one
//   combinational pass between the input register and the result register.
// Stall:
//   While a result waits under out_stall, bytes that do not finish a frame
//   keep flowing; only a byte that would finish another frame is held, and
//   in_stall then rises until the waiting result is taken.
// Reset:
//   rst_n clears the parser to sync hunt, empties both registers and sets the
//   module address to 0xEE.
module crsf_frame_deframer_crc_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] verdict,
    output logic [7:0] frame_type,
    output logic [7:0] dest_addr,
    output logic [7:0] orig_addr,
    output logic [7:0] field_id,
    output logic [7:0] arg_value,
    output logic [6:0] total_len,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] own_address
);
    import crsf_pkg::*;

    // Input register
    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;

    // Parser state
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] exp_len_reg, exp_len_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       hdr_reg [HDR_N];
    logic [7:0]       hdr_next [HDR_N];

    // Config
    logic [7:0]       own_addr_reg;

    // Result register
    logic             out_valid_reg, out_valid_next;
    verdict_t         verdict_reg, verdict_next;
    logic [7:0]       type_reg, dest_reg, orig_reg, fid_reg, arg_reg;
    logic [CNT_W-1:0] total_reg, total_next;

    logic             accept;
    logic             emit;
    logic             step;
    logic             out_free;
    logic [CNT_W-1:0] frame_total;
    logic [CNT_W-1:0] pos_inc;

    assign cfg_ready = 1'b1;

    // Result register can take a new frame when empty or being drained now.
    assign out_free = !out_valid_reg || !out_stall;
    // Hold a frame-ending byte while the previous result still waits.
    assign step     = in_valid_reg && (!emit || out_free);
    assign in_stall = in_valid_reg && !step;
    assign accept   = in_valid && !in_stall;

    assign frame_total = CNT_W'(exp_len_reg) + CNT_W'(2);
    assign pos_inc     = count_reg + CNT_W'(1);

    // Parser step for the byte in the input register.
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        exp_len_next = exp_len_reg;
        crc_next     = crc_reg;
        hdr_next     = hdr_reg;
        emit         = 1'b0;
        verdict_next = V_IGNORED;
        total_next   = frame_total;

        unique case (phase_reg)
            PH_LEN:
            begin
                if (in_byte_reg < LEN_MIN || in_byte_reg > LEN_MAX)
                begin
                    // Drop an out-of-range length, resume sync hunt.
                    phase_next = PH_SYNC;
                    count_next = '0;
                end
                else
                begin
                    exp_len_next = in_byte_reg[LEN_W-1:0];
                    count_next   = CNT_W'(2);
                    crc_next     = '0;
                    for (int i = 0; i < HDR_N; i++)
                    begin
                        hdr_next[i] = '0;
                    end
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (count_reg <= CNT_W'(exp_len_reg))
                begin
                    crc_next = crc8_update(crc_reg, in_byte_reg);
                    for (int i = 0; i < HDR_N; i++)
                    begin
                        if (count_reg == CNT_W'(i + 2))
                        begin
                            hdr_next[i] = in_byte_reg;
                        end
                    end
                end
                count_next = pos_inc;
                if (pos_inc == frame_total)
                begin
                    // Last byte is the CRC; it is never captured or hashed.
                    emit = 1'b1;
                    if (crc_reg != in_byte_reg)
                        verdict_next = V_BAD_CRC;
                    else if (frame_total < CNT_W'(6))
                        verdict_next = V_TOO_SHORT;
                    else if (hdr_reg[0] == TYPE_PING)
                        verdict_next = (hdr_reg[1] == ADDR_BCAST || hdr_reg[1] == own_addr_reg)
                                       ? V_PING_US : V_PING_OTHER;
                    else if (hdr_reg[0] == TYPE_PREAD && hdr_reg[1] == own_addr_reg
                             && frame_total >= CNT_W'(8))
                        verdict_next = V_PREAD;
                    else if (hdr_reg[0] == TYPE_PWRITE && hdr_reg[1] == own_addr_reg
                             && frame_total >= CNT_W'(8))
                        verdict_next = V_PWRITE;
                    else
                        verdict_next = V_IGNORED;
                    phase_next = PH_SYNC;
                    count_next = '0;
                end
            end
            default:
            begin
                // Sync hunt: main sync byte or our own address.
                phase_next = PH_SYNC;
                if (in_byte_reg == SYNC_MAIN || in_byte_reg == own_addr_reg)
                begin
                    phase_next = PH_LEN;
                    count_next = CNT_W'(1);
                end
            end
        endcase
    end

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (step && emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SYNC;
            count_reg     <= '0;
            exp_len_reg   <= '0;
            crc_reg       <= '0;
            own_addr_reg  <= OWN_ADDR_RST;
            for (int i = 0; i < HDR_N; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                own_addr_reg <= own_address;
            end
            if (step)
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                exp_len_reg <= exp_len_next;
                crc_reg     <= crc_next;
                hdr_reg     <= hdr_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && emit)
        begin
            verdict_reg <= verdict_next;
            type_reg    <= hdr_reg[0];
            dest_reg    <= hdr_reg[1];
            orig_reg    <= hdr_reg[2];
            fid_reg     <= hdr_reg[3];
            arg_reg     <= hdr_reg[4];
            total_reg   <= total_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign verdict    = verdict_reg;
    assign frame_type = type_reg;
    assign dest_addr  = dest_reg;
    assign orig_addr  = orig_reg;
    assign field_id   = fid_reg;
    assign arg_value  = arg_reg;
    assign total_len  = total_reg;

`ifndef NO_ASSERTIONS
    // A waiting result is never overwritten or lost.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(total_reg))
        else $error("pending result lost or overwritten");

    // While collecting, the position never runs past the frame end.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (count_reg <= frame_total && exp_len_reg >= LEN_MIN[LEN_W-1:0]))
        else $error("frame position out of range");

    // A completed frame returns the parser to sync hunt and shows a result.
    a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |=> (phase_reg == PH_SYNC && out_valid_reg))
        else $error("frame completion not handled");

    // Input is held only for a frame-ending byte behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && emit && out_valid_reg && out_stall))
        else $error("unexpected input stall");
`endif

endmodule
